// File: rtl/core/blv_pkg.sv
package blv_pkg;

  localparam int ADDR_W   = 3;
  localparam int GRAV_W   = 12;
  localparam int TQ_W     = 18;
  localparam int HALF_W   = 21;
  localparam int NEAR_W   = 16;
  localparam int S_W      = 33;
  localparam int S_LIM_W  = 28;
  localparam int DQ_W     = 30;
  localparam int DQ_SHIFT = 17;
  localparam int Q_W      = DQ_W + DQ_SHIFT;
  localparam int RT_W     = (Q_W + 1) / 2;
  localparam int VEL_SHIFT  = 24;
  localparam int HALF_SHIFT = 9;
  localparam int VEL_W    = 32;

  localparam logic [TQ_W-1:0] T_ONE = 18'd65536;
  localparam logic [TQ_W-1:0] T_MIN = 18'd32768;
  localparam logic [TQ_W-1:0] T_MAX = 18'd163840;

  localparam logic [GRAV_W-1:0] GRAVITY_RESET = 12'd800;
  localparam logic [ADDR_W-3:0] REG_GRAVITY   = 1'd0;

  typedef struct packed {
    logic zero;
    logic big;
    logic horiz;
  } blv_flags_t;

endpackage

// File: rtl/core/ballistic_launch_velocity_top.sv
// Launch velocity for a ballistic shot from a start to a target point under the gravity
// register (offset 0x0, reset 800). One transfer can be accepted every clock unless the
// output is stalled; each input gives exactly one result, passing through the
// bit-per-stage pipelines: two square roots (30 and 24 stages), the flight
// time divide (47 stages) and the three velocity divides (COORD_BITS + 25 stages).
// The whole pipeline stalls only while a result waits at the output.
module ballistic_launch_velocity_top #(
  parameter int COORD_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [blv_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [COORD_BITS-1:0]   start_x,
  input  logic signed [COORD_BITS-1:0]   start_y,
  input  logic signed [COORD_BITS-1:0]   start_z,
  input  logic signed [COORD_BITS-1:0]   target_x,
  input  logic signed [COORD_BITS-1:0]   target_y,
  input  logic signed [COORD_BITS-1:0]   target_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [31:0]             vel_x,
  output logic signed [31:0]             vel_y,
  output logic signed [31:0]             vel_z
);

  localparam int DW  = COORD_BITS + 1;
  localparam int NW  = DW + blv_pkg::VEL_SHIFT;
  localparam int SW  = NW + 2;
  localparam int PW1 = 3 * DW + 3;
  localparam int PW2 = 4 + blv_pkg::HALF_W;
  localparam logic signed [SW-1:0] SMAX = SW'(2147483647);
  localparam logic signed [SW-1:0] SMIN = ~SMAX;

  logic en;
  logic [blv_pkg::GRAV_W-1:0] gravity;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= blv_pkg::GRAVITY_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[blv_pkg::ADDR_W-1:2] == blv_pkg::REG_GRAVITY) begin
      gravity <= pwdata[blv_pkg::GRAV_W-1:0];
    end
  end

  assign prdata = (paddr[blv_pkg::ADDR_W-1:2] == blv_pkg::REG_GRAVITY) ?
                  {{(32-blv_pkg::GRAV_W){1'b0}}, gravity} : '0;

  // differences
  logic a_vld;
  logic signed [DW-1:0] a_dx, a_dy, a_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
    if (en) begin
      a_dx <= DW'(target_x) - DW'(start_x);
      a_dy <= DW'(target_y) - DW'(start_y);
      a_dz <= DW'(target_z) - DW'(start_z);
    end
  end

  // magnitudes
  logic [DW-1:0] a_ax, a_ay;
  logic b_vld, b_zero, b_far;
  logic signed [DW-1:0] b_dx, b_dy, b_dz;
  logic [blv_pkg::NEAR_W-1:0] b_ax16, b_ay16;

  assign a_ax = a_dx[DW-1] ? DW'(-a_dx) : DW'(a_dx);
  assign a_ay = a_dy[DW-1] ? DW'(-a_dy) : DW'(a_dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
    if (en) begin
      b_dx   <= a_dx;
      b_dy   <= a_dy;
      b_dz   <= a_dz;
      b_zero <= a_ax == '0 && a_ay == '0;
      b_far  <= (a_ax >> blv_pkg::NEAR_W) != '0 || (a_ay >> blv_pkg::NEAR_W) != '0;
      b_ax16 <= blv_pkg::NEAR_W'(a_ax);
      b_ay16 <= blv_pkg::NEAR_W'(a_ay);
    end
  end

  // squares
  logic c_vld, c_zero, c_far;
  logic signed [DW-1:0] c_dx, c_dy, c_dz;
  logic [2*blv_pkg::NEAR_W-1:0] c_sqx, c_sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= b_vld;
    end
    if (en) begin
      c_dx   <= b_dx;
      c_dy   <= b_dy;
      c_dz   <= b_dz;
      c_zero <= b_zero;
      c_far  <= b_far;
      c_sqx  <= {{blv_pkg::NEAR_W{1'b0}}, b_ax16} * {{blv_pkg::NEAR_W{1'b0}}, b_ax16};
      c_sqy  <= {{blv_pkg::NEAR_W{1'b0}}, b_ay16} * {{blv_pkg::NEAR_W{1'b0}}, b_ay16};
    end
  end

  // sum of squares and the special cases
  logic [blv_pkg::S_W-1:0] c_s;
  logic d_vld;
  blv_pkg::blv_flags_t d_flags;
  logic signed [DW-1:0] d_dx, d_dy, d_dz;
  logic [2*blv_pkg::DQ_W-1:0] d_rad;

  assign c_s = {1'b0, c_sqx} + {1'b0, c_sqy};

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld <= c_vld;
    end
    if (en) begin
      d_dx          <= c_dx;
      d_dy          <= c_dy;
      d_dz          <= c_dz;
      d_flags.zero  <= c_zero;
      d_flags.big   <= !c_zero && (c_far || c_s[blv_pkg::S_W-1:blv_pkg::S_LIM_W] != '0 ||
                                   gravity == '0);
      d_flags.horiz <= !c_zero && (c_far || c_s > blv_pkg::S_W'(1));
      d_rad         <= {c_s[blv_pkg::S_LIM_W-1:0],
                        {(2*blv_pkg::DQ_W-blv_pkg::S_LIM_W){1'b0}}};
    end
  end

  // distance, 2d/g, flight time
  logic p1_vld, p2_vld, p3_vld;
  logic [PW1-1:0] p1_pay, p2_pay, p3_pay;
  logic [blv_pkg::DQ_W-1:0] dq;
  logic [0:0][blv_pkg::Q_W-1:0] q;
  logic [blv_pkg::RT_W-1:0] rt;

  blv_sqrt_pipe #(
    .IN_W (2 * blv_pkg::DQ_W),
    .PW   (PW1)
  ) u_sqrt_dist (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (d_vld),
    .rad     (d_rad),
    .in_pay  ({d_dx, d_dy, d_dz, d_flags}),
    .out_vld (p1_vld),
    .root    (dq),
    .out_pay (p1_pay)
  );

  blv_div_pipe #(
    .NUM_W (blv_pkg::Q_W),
    .DEN_W (blv_pkg::GRAV_W),
    .LANES (1),
    .PW    (PW1)
  ) u_div_grav (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (p1_vld),
    .num     ({dq, {blv_pkg::DQ_SHIFT{1'b0}}}),
    .den     (gravity),
    .in_pay  (p1_pay),
    .out_vld (p2_vld),
    .quo     (q),
    .out_pay (p2_pay)
  );

  blv_sqrt_pipe #(
    .IN_W (2 * blv_pkg::RT_W),
    .PW   (PW1)
  ) u_sqrt_time (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (p2_vld),
    .rad     ({{(2*blv_pkg::RT_W-blv_pkg::Q_W){1'b0}}, q[0]}),
    .in_pay  (p2_pay),
    .out_vld (p3_vld),
    .root    (rt),
    .out_pay (p3_pay)
  );

  // clamp, magnitudes for the velocity divides
  logic signed [DW-1:0] p3_dx, p3_dy, p3_dz;
  blv_pkg::blv_flags_t p3_flags;
  logic e_vld;
  blv_pkg::blv_flags_t e_flags;
  logic [blv_pkg::TQ_W-1:0] e_tq;
  logic [DW-1:0] e_ax, e_ay, e_az;
  logic e_sx, e_sy, e_sz;

  assign {p3_dx, p3_dy, p3_dz, p3_flags} = p3_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (en) begin
      e_vld <= p3_vld;
    end
    if (en) begin
      e_flags <= p3_flags;
      priority if (p3_flags.zero) begin
        e_tq <= blv_pkg::T_ONE;
      end else if (p3_flags.big) begin
        e_tq <= blv_pkg::T_MAX;
      end else if (rt < blv_pkg::RT_W'(blv_pkg::T_MIN)) begin
        e_tq <= blv_pkg::T_MIN;
      end else if (rt > blv_pkg::RT_W'(blv_pkg::T_MAX)) begin
        e_tq <= blv_pkg::T_MAX;
      end else begin
        e_tq <= rt[blv_pkg::TQ_W-1:0];
      end
      e_sx <= p3_dx[DW-1];
      e_sy <= p3_dy[DW-1];
      e_sz <= p3_dz[DW-1];
      e_ax <= p3_dx[DW-1] ? DW'(-p3_dx) : DW'(p3_dx);
      e_ay <= p3_dy[DW-1] ? DW'(-p3_dy) : DW'(p3_dy);
      e_az <= p3_dz[DW-1] ? DW'(-p3_dz) : DW'(p3_dz);
    end
  end

  logic [blv_pkg::GRAV_W+blv_pkg::TQ_W-1:0] e_gt;
  logic [blv_pkg::HALF_W-1:0] e_half;

  assign e_gt   = {{blv_pkg::TQ_W{1'b0}}, gravity} * {{blv_pkg::GRAV_W{1'b0}}, e_tq};
  assign e_half = e_gt[blv_pkg::HALF_SHIFT +: blv_pkg::HALF_W];

  // velocity divides, lane 2 is x, lane 1 y, lane 0 z
  logic p4_vld;
  logic [PW2-1:0] p4_pay;
  logic [2:0][NW-1:0] vq;

  blv_div_pipe #(
    .NUM_W (NW),
    .DEN_W (blv_pkg::TQ_W),
    .LANES (3),
    .PW    (PW2)
  ) u_div_vel (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (e_vld),
    .num     ({{e_ax, {blv_pkg::VEL_SHIFT{1'b0}}},
               {e_ay, {blv_pkg::VEL_SHIFT{1'b0}}},
               {e_az, {blv_pkg::VEL_SHIFT{1'b0}}}}),
    .den     (e_tq),
    .in_pay  ({e_sx, e_sy, e_sz, e_flags.horiz, e_half}),
    .out_vld (p4_vld),
    .quo     (vq),
    .out_pay (p4_pay)
  );

  // sign, add g*t/2, saturate
  function automatic logic [31:0] sat32(input logic signed [SW-1:0] v);
    priority if (v > SMAX) begin
      return 32'h7FFF_FFFF;
    end else if (v < SMIN) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  logic p4_sx, p4_sy, p4_sz, p4_horiz;
  logic [blv_pkg::HALF_W-1:0] p4_half;
  logic signed [SW-1:0] wx, wy, wz;

  assign {p4_sx, p4_sy, p4_sz, p4_horiz, p4_half} = p4_pay;
  assign wx = p4_sx ? -$signed({2'b00, vq[2]}) : $signed({2'b00, vq[2]});
  assign wy = p4_sy ? -$signed({2'b00, vq[1]}) : $signed({2'b00, vq[1]});
  assign wz = (p4_sz ? -$signed({2'b00, vq[0]}) : $signed({2'b00, vq[0]})) +
              $signed({{(SW-blv_pkg::HALF_W){1'b0}}, p4_half});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= p4_vld;
    end
    if (en) begin
      vel_x <= p4_horiz ? sat32(wx) : '0;
      vel_y <= p4_horiz ? sat32(wy) : '0;
      vel_z <= sat32(wz);
    end
  end

  a_tq_range: assert property (@(posedge clk) disable iff (rst)
    e_vld |-> e_tq >= blv_pkg::T_MIN && e_tq <= blv_pkg::T_MAX)
    else $error("flight time outside clamp range");

  a_zero_not_horiz: assert property (@(posedge clk) disable iff (rst)
    e_vld && e_flags.zero |-> !e_flags.horiz && e_tq == blv_pkg::T_ONE)
    else $error("zero distance marked horizontal");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(e_tq) && $stable(e_vld) && $stable(d_vld))
    else $error("pipeline moved during stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !e_vld)
    else $error("pipeline not empty after reset");

endmodule

// File: rtl/core/blv_sqrt_pipe.sv
module blv_sqrt_pipe #(
  parameter int IN_W = 60,
  parameter int PW   = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [IN_W-1:0]   rad,
  input  logic [PW-1:0]     in_pay,
  output logic              out_vld,
  output logic [IN_W/2-1:0] root,
  output logic [PW-1:0]     out_pay
);

  localparam int N  = IN_W / 2;
  localparam int RW = N + 2;

  logic [RW-1:0]   rem_q  [N];
  logic [N-1:0]    root_q [N];
  logic [IN_W-1:0] rad_q  [N];
  logic [PW-1:0]   pay_q  [N];
  logic            vld_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RW-1:0]   rem_in;
    logic [N-1:0]    root_in;
    logic [IN_W-1:0] rad_in;
    logic [PW-1:0]   pay_in;
    logic            vld_in;
    logic [RW-1:0]   rem2;
    logic [RW-1:0]   trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
      assign pay_in  = in_pay;
      assign vld_in  = in_vld;
    end else begin : g_rest
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign pay_in  = pay_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign rem2  = {rem_in[RW-3:0], rad_in[IN_W-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_in;
      end
      if (en) begin
        rem_q[k]  <= ge ? rem2 - trial : rem2;
        root_q[k] <= {root_in[N-2:0], ge};
        rad_q[k]  <= rad_in << 2;
        pay_q[k]  <= pay_in;
      end
    end
  end

  assign out_vld = vld_q[N-1];
  assign root    = root_q[N-1];
  assign out_pay = pay_q[N-1];

endmodule

// File: rtl/core/blv_div_pipe.sv
module blv_div_pipe #(
  parameter int NUM_W = 47,
  parameter int DEN_W = 12,
  parameter int LANES = 1,
  parameter int PW    = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [LANES-1:0][NUM_W-1:0] num,
  input  logic [DEN_W-1:0]            den,
  input  logic [PW-1:0]               in_pay,
  output logic                        out_vld,
  output logic [LANES-1:0][NUM_W-1:0] quo,
  output logic [PW-1:0]               out_pay
);

  logic [LANES-1:0][DEN_W-1:0] rem_q [NUM_W];
  logic [LANES-1:0][NUM_W-1:0] nq_q  [NUM_W];
  logic [DEN_W-1:0]            den_q [NUM_W];
  logic [PW-1:0]               pay_q [NUM_W];
  logic                        vld_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [LANES-1:0][DEN_W-1:0] rem_in;
    logic [LANES-1:0][NUM_W-1:0] nq_in;
    logic [DEN_W-1:0]            den_in;
    logic [PW-1:0]               pay_in;
    logic                        vld_in;
    logic [LANES-1:0][DEN_W-1:0] rem_next;
    logic [LANES-1:0][NUM_W-1:0] nq_next;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num;
      assign den_in = den;
      assign pay_in = in_pay;
      assign vld_in = in_vld;
    end else begin : g_rest
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign den_in = den_q[k-1];
      assign pay_in = pay_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W:0] rem2;
      logic [DEN_W:0] diff;
      logic           ge;
      assign rem2 = {rem_in[l], nq_in[l][NUM_W-1]};
      assign diff = rem2 - {1'b0, den_in};
      assign ge   = rem2 >= {1'b0, den_in};
      assign rem_next[l] = ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
      assign nq_next[l]  = {nq_in[l][NUM_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_in;
      end
      if (en) begin
        rem_q[k] <= rem_next;
        nq_q[k]  <= nq_next;
        den_q[k] <= den_in;
        pay_q[k] <= pay_in;
      end
    end
  end

  assign out_vld = vld_q[NUM_W-1];
  assign quo     = nq_q[NUM_W-1];
  assign out_pay = pay_q[NUM_W-1];

endmodule

// File: sim/ballistic_launch_velocity_top_tb.sv
`timescale 1ns / 1ps

module ballistic_launch_velocity_top_tb;

  localparam int CB = 20;
  localparam int LATENCY = CB + 132;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [blv_pkg::TQ_W-1:0] TQ_ONE = blv_pkg::T_ONE;
  localparam logic [blv_pkg::TQ_W-1:0] TQ_MIN = blv_pkg::T_MIN;
  localparam logic [blv_pkg::TQ_W-1:0] TQ_MAX = blv_pkg::T_MAX;

  typedef struct packed {
    logic signed [CB-1:0] sx, sy, sz, tx, ty, tz;
  } shot_t;

  typedef struct packed {
    logic signed [31:0] vx, vy, vz;
  } launch_t;

  typedef struct packed {
    shot_t   shot;
    logic    fixed;
    launch_t want;
  } vector_t;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [blv_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [CB-1:0] start_x, start_y, start_z, target_x, target_y, target_z;
  logic signed [31:0] vel_x, vel_y, vel_z;

  ballistic_launch_velocity_top #(.COORD_BITS(CB)) uut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .start_x(start_x), .start_y(start_y), .start_z(start_z),
    .target_x(target_x), .target_y(target_y), .target_z(target_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z)
  );

  logic [blv_pkg::GRAV_W-1:0] grav_model;
  launch_t launch_q[$];
  int mismatches, watchdog;
  logic stall_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint per_flight(longint num, longint unsigned tq);
    return (num * (64'sd1 <<< 24)) / longint'(tq);
  endfunction

  function automatic launch_t aim(shot_t s, logic [blv_pkg::GRAV_W-1:0] g);
    longint dx, dy, dz;
    longint unsigned ax, ay, sq, dq, tq;
    logic horiz;
    launch_t r;
    dx = longint'(s.tx) - longint'(s.sx);
    dy = longint'(s.ty) - longint'(s.sy);
    dz = longint'(s.tz) - longint'(s.sz);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ax == 0 && ay == 0) begin
      tq = TQ_ONE;
      horiz = 1'b0;
    end else if (ax >= 65536 || ay >= 65536) begin
      tq = TQ_MAX;
      horiz = 1'b1;
    end else begin
      sq = ax * ax + ay * ay;
      horiz = sq > 1;
      if (sq >= (64'd1 << 28) || g == 0) begin
        tq = TQ_MAX;
      end else begin
        dq = root64(sq << 32);
        tq = root64((dq << 17) / g);
        if (tq < TQ_MIN) tq = TQ_MIN;
        if (tq > TQ_MAX) tq = TQ_MAX;
      end
    end
    r.vz = clip32(per_flight(dz, tq) + longint'((longint'(g) * tq) >> 9));
    r.vx = horiz ? clip32(per_flight(dx, tq)) : 32'sd0;
    r.vy = horiz ? clip32(per_flight(dy, tq)) : 32'sd0;
    return r;
  endfunction

  task automatic write_gravity(logic [blv_pkg::GRAV_W-1:0] g);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = blv_pkg::ADDR_W'(blv_pkg::REG_GRAVITY) << 2;
    pwdata = 32'(g);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    grav_model = g;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic drain_and_settle();
    while (launch_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  // on entry we are at a negedge; returns at the negedge after the transfer
  task automatic send_shot(shot_t s, logic fixed, launch_t want);
    launch_t pred;
    start_x = s.sx; start_y = s.sy; start_z = s.sz;
    target_x = s.tx; target_y = s.ty; target_z = s.tz;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = aim(s, grav_model);
    if (fixed && pred != want)
      $display("table row disagrees with predictor: %h vs %h", want, pred);
    launch_q.push_back(fixed ? want : pred);
    @(negedge clk);
  endtask

  function automatic logic signed [CB-1:0] rand_coord(int mode);
    case (mode)
      0: return CB'($urandom);
      1: return CB'($urandom_range(0, 60)) - CB'(30);
      2: return CB'($urandom_range(0, 4000)) - CB'(2000);
      default: return CB'($urandom_range(0, 120000)) - CB'(60000);
    endcase
  endfunction

  function automatic shot_t rand_shot();
    shot_t s;
    int m;
    m = $urandom_range(0, 3);
    s.sx = rand_coord(0); s.sy = rand_coord(0); s.sz = rand_coord(0);
    s.tx = s.sx + rand_coord(m);
    s.ty = s.sy + rand_coord(m);
    s.tz = rand_coord(0);
    if ($urandom_range(0, 15) == 0) begin
      s.tx = s.sx; s.ty = s.sy;
    end else if ($urandom_range(0, 15) == 0) begin
      s.tx = s.sx + CB'(1); s.ty = s.sy;
    end
    return s;
  endfunction

  vector_t vectors[] = '{
    '{'{20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0}, 1'b1,
      '{32'sd0, 32'sd0, 32'sd102400}},
    '{'{20'sd5, -20'sd7, 20'sd0, 20'sd5, -20'sd7, 20'sd100}, 1'b1,
      '{32'sd0, 32'sd0, 32'sd128000}},
    '{'{20'sd0, 20'sd0, 20'sd0, 20'sd1, 20'sd0, 20'sd0}, 1'b0, '0},
    '{'{20'sd0, 20'sd0, 20'sd0, 20'sd0, -20'sd1, 20'sd0}, 1'b0, '0},
    '{'{20'sd0, 20'sd0, 20'sd0, 20'sd1, 20'sd1, 20'sd0}, 1'b0, '0},
    '{'{20'sd0, 20'sd0, 20'sd0, 20'sd3, 20'sd4, 20'sd10}, 1'b0, '0},
    '{'{-20'sd524288, -20'sd524288, -20'sd524288, 20'sd524287, 20'sd524287,
        20'sd524287}, 1'b0, '0},
    '{'{20'sd524287, 20'sd524287, 20'sd524287, -20'sd524288, -20'sd524288,
        -20'sd524288}, 1'b0, '0},
    '{'{20'sd0, 20'sd0, 20'sd0, 20'sd65535, 20'sd0, 20'sd0}, 1'b0, '0},
    '{'{20'sd0, 20'sd0, 20'sd0, 20'sd65536, 20'sd0, 20'sd0}, 1'b0, '0},
    '{'{20'sd0, 20'sd0, 20'sd0, 20'sd0, -20'sd65536, 20'sd0}, 1'b0, '0},
    '{'{20'sd0, 20'sd0, 20'sd0, 20'sd11585, 20'sd11586, 20'sd0}, 1'b0, '0},
    '{'{20'sd0, 20'sd0, 20'sd0, 20'sd16384, 20'sd0, -20'sd5}, 1'b0, '0},
    '{'{20'sd100, 20'sd200, -20'sd300, -20'sd400, 20'sd500, 20'sd600}, 1'b0, '0},
    '{'{20'sd0, 20'sd0, 20'sd0, 20'sd2, 20'sd0, 20'sd0}, 1'b0, '0},
    '{'{-20'sd1, -20'sd1, -20'sd1, -20'sd1, -20'sd1, -20'sd1}, 1'b1,
      '{32'sd0, 32'sd0, 32'sd102400}}
  };

  logic [blv_pkg::GRAV_W-1:0] grav_list[] = '{12'd800, 12'd1, 12'd4095, 12'd9, 12'd2048};

  initial begin
    int burst;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0;
    {start_x, start_y, start_z, target_x, target_y, target_z} = '0;
    grav_model = blv_pkg::GRAVITY_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (vectors[i]) send_shot(vectors[i].shot, vectors[i].fixed, vectors[i].want);
    in_valid = 1'b0;
    drain_and_settle();

    foreach (grav_list[p]) begin
      write_gravity(grav_list[p]);
      if (p < 2)
        foreach (vectors[i]) send_shot(vectors[i].shot, 1'b0, '0);
      for (int n = 0; n < 150;) begin
        burst = $urandom_range(1, 20);
        for (int k = 0; k < burst && n < 150 && !(k > 0 && n == 75); k++, n++)
          send_shot(rand_shot(), 1'b0, '0);
        in_valid = 1'b0;
        if (n == 75) begin
          while (launch_q.size() != 0) @(negedge clk);
        end else begin
          repeat ($urandom_range(0, 6)) @(negedge clk);
        end
      end
      in_valid = 1'b0;
      drain_and_settle();
    end

    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    stall_mode = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) stall_mode = ~stall_mode;
      out_ready = stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
    end
  end

  always @(posedge clk) begin
    launch_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{vel_x, vel_y, vel_z};
      if (launch_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer out: %h", got);
      end else begin
        want = launch_q.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: vel_x %0d/%0d vel_y %0d/%0d vel_z %0d/%0d (exp/got)",
                     want.vx, got.vx, want.vy, got.vy, want.vz, got.vz);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      watchdog <= 0;
    end else begin
      watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule
